### src/scb_pkg.sv
// Package for the scaled clock bank: widths, entry layout, action and
// sequencer codes, and the reciprocal used for the divide by 1000.
// No dependencies.
package scb_pkg;

  localparam int NUM_CLOCKS_DEF = 8;

  localparam int IDX_W  = 3;
  localparam int VAL_W  = 32;
  localparam int TIME_W = 32;
  localparam int FRAC_W = 16;
  localparam int RATE_W = 16;
  localparam int ENT_W  = TIME_W + FRAC_W + RATE_W;

  // stream word widths (fields packed from bit 0, padded to bytes)
  localparam int IN_W  = 40;
  localparam int OUT_W = 56;

  localparam logic [RATE_W-1:0] RATE_RST = 16'd1000;

  // (d << 16) / 1000 == (d << 13) / 125 == (d * RECIP_1000) >> 23 for d < 2^16
  localparam logic [31:0] RECIP_1000  = 32'd549755814;  // ceil(2^36 / 125)
  localparam int          RECIP_SHIFT = 23;
  localparam int          QUO_W       = 23;

  typedef enum logic [2:0] {
    ACT_TICK,
    ACT_WR_TIME,
    ACT_WR_RATE,
    ACT_START,
    ACT_STOP,
    ACT_RESET,
    ACT_RESTART,
    ACT_READ
  } action_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_QUO,
    ST_BANK,
    ST_RD,
    ST_UPD,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic [RATE_W-1:0] rate;
    logic [FRAC_W-1:0] frac;
    logic [TIME_W-1:0] tm;
  } entry_t;

endpackage

### src/scb_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module scb_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 8,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### src/scb_mul.sv
// Shared 32x32 multiplier with registered product.
// Used for the reciprocal divide and for the per-clock rate scaling.
module scb_mul (
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [63:0] prod
);

  logic [63:0] prod_r;

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= a * b;
    end
  end

  assign prod = prod_r;

endmodule

### src/scaled_clock_bank.sv
// Scaled clock bank top level: sequencer, entry RAM and shared multiplier.
// Depends on scb_pkg, scb_ram and scb_mul.
//
// Usage:
//   in_*  : one word per action (tick, time write, rate write, start, stop,
//           reset, restart, read) addressed to one clock of the bank.
//   out_* : exactly one result word per action: the addressed clock's time,
//           rate and running flag after the action (all zero when the index
//           lies beyond the bank).
// Sequencing (one word in flight at a time, in_tready low while busy):
//   non-tick actions: from accept to out_tvalid the word passes the entry
//     read, update and output load states; the next word is taken after that.
//   tick: the divide, quotient and bank sweep states come before the same
//     read, update and output load. The divide by 1000 runs through the shared
//     multiplier; then the bank sweep reads one clock per cycle from the entry
//     RAM, scales its rate in the same multiplier and, for a running clock,
//     writes it back after the RAM read and product registers, then drains.
// Reset: rst_n (synchronous, active low) clears the sequencer, the last
//   global time, the running flags and the per-entry valid bits; an entry
//   whose valid bit is clear reads as time 0, fraction 0, rate 1000.
// Stall: the result sits in the output register until out_tready; the block
//   accepts the next word meanwhile and holds its next result until the
//   output register is free.
module scaled_clock_bank
  import scb_pkg::*;
#(
  parameter int NUM_CLOCKS = NUM_CLOCKS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  // in_tdata: [2:0] action, [5:3] clock_index, [37:6] value, [39:38] zero
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [IN_W-1:0]  in_tdata,
  // out_tdata: [31:0] clock_time, [47:32] clock_rate, [48] clock_running,
  //            [55:49] zero
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [OUT_W-1:0] out_tdata
);

  localparam int AW = (NUM_CLOCKS > 1) ? $clog2(NUM_CLOCKS) : 1;
  localparam int CW = $clog2(NUM_CLOCKS + 1);

  localparam entry_t ENT_RST = '{rate: RATE_RST, frac: '0, tm: '0};

  // sequencer and latched input word
  state_t              state_r, state_nxt;
  action_t             act_r, act_nxt;
  logic [IDX_W-1:0]    idx_r, idx_nxt;
  logic [VAL_W-1:0]    val_r, val_nxt;
  logic [VAL_W-1:0]    last_r, last_nxt;
  logic [31:0]         per_unit_r, per_unit_nxt;
  logic [CW-1:0]       cnt_r, cnt_nxt;

  // sweep pipeline: stage 1 = RAM data out, stage 2 = product ready
  logic                v1_r, v1_nxt;
  logic                v2_r, v2_nxt;
  logic [AW-1:0]       k1_r, k1_nxt;
  logic [AW-1:0]       k2_r, k2_nxt;
  logic                run1_r, run1_nxt;
  logic                vld1_r, vld1_nxt;
  logic                run2_r, run2_nxt;
  logic [TIME_W-1:0]   tm2_r, tm2_nxt;
  logic [FRAC_W-1:0]   frac2_r, frac2_nxt;
  logic [RATE_W-1:0]   rate2_r, rate2_nxt;

  logic [OUT_W-1:0]    res_r, res_nxt;
  logic                out_tvalid_r, out_tvalid_nxt;
  logic [OUT_W-1:0]    out_tdata_r, out_tdata_nxt;

  // per-clock flops
  logic                ent_vld_r [NUM_CLOCKS];
  logic                running_r [NUM_CLOCKS];

  logic                ram_we, ram_re;
  logic [AW-1:0]       ram_waddr, ram_raddr;
  logic [ENT_W-1:0]    ram_wdata, ram_rdata;
  logic                run_we, run_wval;

  logic                mul_en;
  logic [31:0]         mul_a, mul_b;
  logic [63:0]         mul_prod;

  logic                idx_ok;
  logic [AW-1:0]       idx_addr;
  logic [VAL_W-1:0]    diff;
  entry_t              ent_rd;
  entry_t              ent_upd;
  logic                run_upd;
  logic [31:0]         sum;
  logic [AW-1:0]       iss_addr;

  assign idx_ok   = int'(idx_r) < NUM_CLOCKS;
  assign idx_addr = AW'(idx_r);
  assign diff     = val_r - last_r;
  assign ent_rd   = vld1_r ? entry_t'(ram_rdata) : ENT_RST;
  assign sum      = {16'b0, frac2_r} + mul_prod[31:0];
  assign iss_addr = cnt_r[AW-1:0];

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  scb_ram #(
    .WIDTH (ENT_W),
    .DEPTH (NUM_CLOCKS),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  scb_mul u_mul (
    .clk  (clk),
    .en   (mul_en),
    .a    (mul_a),
    .b    (mul_b),
    .prod (mul_prod)
  );

  always_comb begin
    state_nxt      = state_r;
    act_nxt        = act_r;
    idx_nxt        = idx_r;
    val_nxt        = val_r;
    last_nxt       = last_r;
    per_unit_nxt   = per_unit_r;
    cnt_nxt        = cnt_r;
    v1_nxt         = 1'b0;
    v2_nxt         = 1'b0;
    k1_nxt         = k1_r;
    k2_nxt         = k2_r;
    run1_nxt       = run1_r;
    vld1_nxt       = vld1_r;
    run2_nxt       = run2_r;
    tm2_nxt        = tm2_r;
    frac2_nxt      = frac2_r;
    rate2_nxt      = rate2_r;
    res_nxt        = res_r;
    out_tvalid_nxt = out_tvalid_r;
    out_tdata_nxt  = out_tdata_r;

    ram_we    = 1'b0;
    ram_waddr = k2_r;
    ram_wdata = {rate2_r, sum[FRAC_W-1:0], tm2_r + {16'b0, sum[31:16]}};
    ram_re    = 1'b0;
    ram_raddr = idx_addr;
    run_we    = 1'b0;
    run_wval  = 1'b0;
    mul_en    = 1'b0;
    mul_a     = per_unit_r;
    mul_b     = {16'b0, ent_rd.rate};
    ent_upd   = ent_rd;
    run_upd   = run1_r;

    if (out_tvalid_r && out_tready) begin
      out_tvalid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          act_nxt   = action_t'(in_tdata[2:0]);
          idx_nxt   = in_tdata[5:3];
          val_nxt   = in_tdata[37:6];
          state_nxt = (action_t'(in_tdata[2:0]) == ACT_TICK) ? ST_DIV : ST_RD;
        end
      end

      ST_DIV: begin
        // only the low 16 bits of diff survive the 32-bit shift by 16
        mul_en    = 1'b1;
        mul_a     = {16'b0, diff[15:0]};
        mul_b     = RECIP_1000;
        last_nxt  = val_r;
        cnt_nxt   = '0;
        state_nxt = ST_QUO;
      end

      ST_QUO: begin
        per_unit_nxt = 32'(mul_prod[RECIP_SHIFT +: QUO_W]);
        state_nxt    = ST_BANK;
      end

      ST_BANK: begin
        // issue one read per cycle
        if (int'(cnt_r) < NUM_CLOCKS) begin
          ram_re    = 1'b1;
          ram_raddr = iss_addr;
          cnt_nxt   = CW'(cnt_r + 1'b1);
          v1_nxt    = 1'b1;
          k1_nxt    = iss_addr;
          run1_nxt  = running_r[iss_addr];
          vld1_nxt  = ent_vld_r[iss_addr];
        end
        // stage 1: scale rate
        if (v1_r) begin
          mul_en    = 1'b1;
          v2_nxt    = 1'b1;
          k2_nxt    = k1_r;
          run2_nxt  = run1_r;
          tm2_nxt   = ent_rd.tm;
          frac2_nxt = ent_rd.frac;
          rate2_nxt = ent_rd.rate;
        end
        // stage 2: accumulate fraction, carry into time
        if (v2_r && run2_r) begin
          ram_we = 1'b1;
        end
        if (int'(cnt_r) == NUM_CLOCKS && !v1_r && !v2_r) begin
          state_nxt = ST_RD;
        end
      end

      ST_RD: begin
        ram_re    = 1'b1;
        ram_raddr = idx_addr;
        run1_nxt  = idx_ok ? running_r[idx_addr] : 1'b0;
        vld1_nxt  = idx_ok ? ent_vld_r[idx_addr] : 1'b0;
        state_nxt = ST_UPD;
      end

      ST_UPD: begin
        unique case (act_r)
          ACT_WR_TIME: ent_upd.tm   = val_r;
          ACT_WR_RATE: ent_upd.rate = val_r[RATE_W-1:0];
          ACT_START:   run_upd      = 1'b1;
          ACT_STOP:    run_upd      = 1'b0;
          ACT_RESET: begin
            ent_upd.tm   = '0;
            ent_upd.frac = '0;
          end
          ACT_RESTART: begin
            ent_upd.tm   = '0;
            ent_upd.frac = '0;
            run_upd      = 1'b1;
          end
          ACT_TICK, ACT_READ: ;
        endcase
        if (idx_ok) begin
          ram_we    = (act_r == ACT_WR_TIME) || (act_r == ACT_WR_RATE) ||
                      (act_r == ACT_RESET) || (act_r == ACT_RESTART);
          ram_waddr = idx_addr;
          ram_wdata = ent_upd;
          run_we    = (act_r == ACT_START) || (act_r == ACT_STOP) ||
                      (act_r == ACT_RESTART);
          run_wval  = run_upd;
          res_nxt   = {7'b0, run_upd, ent_upd.rate, ent_upd.tm};
        end else begin
          res_nxt   = '0;
        end
        state_nxt = ST_OUT;
      end

      ST_OUT: begin
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          out_tdata_nxt  = res_r;
          state_nxt      = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      last_r       <= '0;
      cnt_r        <= '0;
      v1_r         <= 1'b0;
      v2_r         <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      last_r       <= last_nxt;
      cnt_r        <= cnt_nxt;
      v1_r         <= v1_nxt;
      v2_r         <= v2_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    act_r       <= act_nxt;
    idx_r       <= idx_nxt;
    val_r       <= val_nxt;
    per_unit_r  <= per_unit_nxt;
    k1_r        <= k1_nxt;
    k2_r        <= k2_nxt;
    run1_r      <= run1_nxt;
    vld1_r      <= vld1_nxt;
    run2_r      <= run2_nxt;
    tm2_r       <= tm2_nxt;
    frac2_r     <= frac2_nxt;
    rate2_r     <= rate2_nxt;
    res_r       <= res_nxt;
    out_tdata_r <= out_tdata_nxt;
  end

  // valid bits: an entry reads as its reset value until first written
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_CLOCKS; i++) begin
        ent_vld_r[i] <= 1'b0;
        running_r[i] <= 1'b0;
      end
    end else begin
      if (ram_we) begin
        ent_vld_r[ram_waddr] <= 1'b1;
      end
      if (run_we) begin
        running_r[idx_addr] <= run_wval;
      end
    end
  end

endmodule

### src/scb_checker.sv
// Port-level checker for scaled_clock_bank, bound to the top level.
// Depends on scb_pkg.
module scb_checker
  import scb_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             in_tvalid,
  input logic             in_tready,
  input logic             out_tvalid,
  input logic             out_tready,
  input logic [OUT_W-1:0] out_tdata
);

  // held result word stays put under backpressure
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result word changed while stalled");

  // nothing pending right after reset
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // one word in flight: busy right after an accept
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("accepted a second word while busy");

  // a non-tick word needs at least the read and update cycles
  a_min_lat: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && !out_tvalid |=> !out_tvalid ##1 !out_tvalid)
    else $error("result produced too early");

  // padding bits of the result word stay zero
  a_out_pad: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[OUT_W-1:49] == '0)
    else $error("nonzero pad bits in result word");

endmodule

bind scaled_clock_bank scb_checker u_scb_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

### dv/testbench.sv
`timescale 1ns / 100ps
// Self-checking bench for scaled_clock_bank: directed and random clock actions
// checked against a cycle-free software copy of the bank, stalls on both streams.
// Depends on scb_pkg and the scaled_clock_bank RTL.
module testbench;
  import scb_pkg::*;

  localparam int BANK         = NUM_CLOCKS_DEF;
  localparam int SLOTS        = 1 << IDX_W;   // every index the field can carry
  localparam int RANDOM_WORDS = 1700;
  localparam int RATE_DIV     = 1000;         // rates are per mille
  localparam int TAIL_CYCLES  = 40;           // quiet tail after the last result

  // one input word, first field in the low bits
  typedef struct packed {
    logic [VAL_W-1:0] value;
    logic [IDX_W-1:0] idx;
    action_t          act;
  } clock_cmd_t;

  // one result word, same layout as out_tdata[48:0]
  typedef struct packed {
    logic              running;
    logic [RATE_W-1:0] rate;
    logic [TIME_W-1:0] tm;
  } clock_view_t;

  logic             clk        = 1'b0;
  logic             rst_n      = 1'b0;
  logic             in_tvalid  = 1'b0;
  logic             in_tready;
  logic [IN_W-1:0]  in_tdata   = '0;
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;

  scaled_clock_bank #(
    .NUM_CLOCKS(BANK)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  initial forever #1 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Software copy of the bank
  // ---------------------------------------------------------------------------
  logic [TIME_W-1:0] bank_time [SLOTS];
  logic [FRAC_W-1:0] bank_frac [SLOTS];
  logic [RATE_W-1:0] bank_rate [SLOTS];
  logic              bank_run  [SLOTS];
  logic [VAL_W-1:0]  last_tick;

  clock_cmd_t  pending_cmds[$];     // words still to be sent
  clock_view_t expected_views[$];   // predicted results, oldest first

  int unsigned mismatch_cnt = 0;

  // Apply one accepted word to the bank copy and queue the view it reports.
  function automatic void apply_clock_cmd(input clock_cmd_t cmd);
    logic [31:0] elapsed;
    logic [31:0] per_unit;
    logic [31:0] step;
    logic [31:0] sum;
    clock_view_t view;
    int          k;
    k = int'(cmd.idx);
    if (cmd.act == ACT_TICK) begin
      // elapsed wraps when global time goes backwards; the shift wraps at 32 bits
      elapsed   = cmd.value - last_tick;
      per_unit  = (elapsed << FRAC_W) / 32'(RATE_DIV);
      last_tick = cmd.value;
      for (int j = 0; j < BANK; j++) begin
        if (bank_run[j]) begin
          step         = per_unit * 32'(bank_rate[j]);
          sum          = 32'(bank_frac[j]) + step;
          bank_time[j] = bank_time[j] + 32'(sum[31:16]);
          bank_frac[j] = sum[15:0];
        end
      end
    end else if (k < BANK) begin
      case (cmd.act)
        ACT_WR_TIME: bank_time[k] = cmd.value;            // fraction kept
        ACT_WR_RATE: bank_rate[k] = cmd.value[RATE_W-1:0]; // upper bits dropped
        ACT_START:   bank_run[k]  = 1'b1;
        ACT_STOP:    bank_run[k]  = 1'b0;
        ACT_RESET: begin
          bank_time[k] = '0;
          bank_frac[k] = '0;
        end
        ACT_RESTART: begin
          bank_time[k] = '0;
          bank_frac[k] = '0;
          bank_run[k]  = 1'b1;
        end
        default: ;
      endcase
    end
    // an index beyond the bank reports all zero
    view = '0;
    if (k < BANK) begin
      view.tm      = bank_time[k];
      view.rate    = bank_rate[k];
      view.running = bank_run[k];
    end
    expected_views.push_back(view);
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatch_cnt++;
    if (mismatch_cnt <= 50)
      $display("%0t ns: %s mismatch, got %h expected %h", $time, what, got, want);
  endtask

  // Idle length: mostly none or short, now and then long.
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic queue_cmd(input action_t act, input int unsigned idx,
                           input logic [31:0] value);
    clock_cmd_t cmd;
    cmd.act   = act;
    cmd.idx   = idx[IDX_W-1:0];
    cmd.value = value;
    pending_cmds.push_back(cmd);
  endtask

  // ---------------------------------------------------------------------------
  // Driver: one word at a time from pending_cmds, random gaps between words.
  // Prediction happens at the edge where the word is accepted.
  // ---------------------------------------------------------------------------
  clock_cmd_t  cur_cmd;
  int unsigned send_gap  = 0;
  bit          send_calm = 1'b0;   // stretch with no gaps on the input side
  bit          word_held;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      word_held = in_tvalid && !in_tready;
      if (in_tvalid && in_tready) apply_clock_cmd(cur_cmd);
      if (!word_held) begin
        if (send_gap > 0) begin
          send_gap--;
          in_tvalid <= 1'b0;
        end else if (pending_cmds.size() > 0) begin
          cur_cmd = pending_cmds.pop_front();
          in_tdata  <= {{(IN_W - $bits(clock_cmd_t)){1'b0}}, cur_cmd};
          in_tvalid <= 1'b1;
          if ($urandom_range(0, 99) == 0) send_calm = !send_calm;
          send_gap = send_calm ? 0 : idle_len();
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: compare each accepted result with the oldest prediction and
  // stall out_tready at random.
  // ---------------------------------------------------------------------------
  clock_view_t seen_view;
  clock_view_t want_view;
  int unsigned recv_gap  = 0;
  bit          recv_calm = 1'b0;   // stretch with no stalls on the output side

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        seen_view = out_tdata[$bits(clock_view_t)-1:0];
        if (expected_views.size() == 0) begin
          report_mismatch("unexpected word", seen_view.tm, '0);
        end else begin
          want_view = expected_views.pop_front();
          if (seen_view.tm !== want_view.tm)
            report_mismatch("clock_time", seen_view.tm, want_view.tm);
          if (seen_view.rate !== want_view.rate)
            report_mismatch("clock_rate", 32'(seen_view.rate), 32'(want_view.rate));
          if (seen_view.running !== want_view.running)
            report_mismatch("clock_running", 32'(seen_view.running),
                            32'(want_view.running));
        end
        if ($urandom_range(0, 99) == 0) recv_calm = !recv_calm;
        recv_gap = recv_calm ? 0 : idle_len();
      end
      if (recv_gap > 0) begin
        recv_gap--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus and end of run
  // ---------------------------------------------------------------------------
  initial begin
    clock_cmd_t      cmd;
    logic [31:0]     stim_now;
    int unsigned     pick;
    int unsigned     form;

    for (int j = 0; j < SLOTS; j++) begin
      bank_time[j] = '0;
      bank_frac[j] = '0;
      bank_rate[j] = RATE_RST;
      bank_run[j]  = 1'b0;
    end
    last_tick = '0;

    // directed: reset state, tick corner cases, every action, index extremes
    queue_cmd(ACT_READ,    0, 32'h0);
    queue_cmd(ACT_READ,    SLOTS-1, 32'hFFFF_FFFF);
    queue_cmd(ACT_TICK,    0, 32'h0);            // zero elapsed
    queue_cmd(ACT_START,   0, 32'h0);
    queue_cmd(ACT_START,   SLOTS-1, 32'h0);
    queue_cmd(ACT_TICK,    3, 32'd1000);         // exactly 1000 units at rate 1000
    queue_cmd(ACT_WR_RATE, SLOTS-1, 32'hFFFF_FFFF); // rate wider than 16 bits
    queue_cmd(ACT_TICK,    SLOTS-1, 32'hFFFF_FFFF);
    queue_cmd(ACT_TICK,    0, 32'd5);            // forward across the wrap
    queue_cmd(ACT_TICK,    0, 32'd3);            // global time going backwards
    queue_cmd(ACT_WR_TIME, 0, 32'hFFFF_FFFF);
    queue_cmd(ACT_TICK,    0, 32'd2003);         // clock time wraps
    queue_cmd(ACT_WR_RATE, 1, 32'h0);            // zero rate
    queue_cmd(ACT_START,   1, 32'h0);
    queue_cmd(ACT_TICK,    1, 32'd2503);
    queue_cmd(ACT_STOP,    SLOTS-1, 32'h0);
    queue_cmd(ACT_TICK,    SLOTS-1, 32'd4000);   // stopped clock holds
    queue_cmd(ACT_RESET,   0, 32'h0);
    queue_cmd(ACT_READ,    0, 32'h0);
    queue_cmd(ACT_RESTART, SLOTS-1, 32'h0);
    queue_cmd(ACT_WR_TIME, 3, 32'hA5A5_A5A5);    // fraction left as it was
    queue_cmd(ACT_STOP,    4, 32'h0);            // already stopped
    queue_cmd(ACT_TICK,    SLOTS-1, 32'd9000);
    queue_cmd(ACT_READ,    3, 32'h5A5A_5A5A);
    stim_now = 32'd9000;

    // random: ticks mostly a short step ahead, some long, some backwards
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      pick      = $urandom_range(0, 99);
      cmd.idx   = IDX_W'($urandom_range(0, SLOTS-1));
      cmd.value = $urandom();
      if (pick < 35) begin
        cmd.act = ACT_TICK;
        form    = $urandom_range(0, 19);
        if (form < 14)      stim_now = stim_now + $urandom_range(1, 5000);
        else if (form < 17) stim_now = stim_now + $urandom_range(0, 65535);
        else if (form < 19) stim_now = $urandom();
        else                stim_now = stim_now - $urandom_range(1, 3000);
        cmd.value = stim_now;
      end else if (pick < 47) begin
        cmd.act = ACT_WR_RATE;
        form    = $urandom_range(0, 19);
        if (form < 10)      cmd.value = $urandom_range(0, 2000);
        else if (form < 16) cmd.value = $urandom_range(0, 65535);
      end else if (pick < 57) begin
        cmd.act = ACT_WR_TIME;
        if ($urandom_range(0, 3) == 0) cmd.value = 32'hFFFF_FFFF - $urandom_range(0, 20000);
      end else if (pick < 67) begin
        cmd.act = ACT_START;
      end else if (pick < 72) begin
        cmd.act = ACT_RESTART;
      end else if (pick < 80) begin
        cmd.act = ACT_STOP;
      end else if (pick < 85) begin
        cmd.act = ACT_RESET;
      end else begin
        cmd.act = ACT_READ;
      end
      pending_cmds.push_back(cmd);
    end

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // all words accepted, then all results in, then a quiet tail
    while (pending_cmds.size() != 0 || in_tvalid) @(posedge clk);
    while (expected_views.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatch_cnt == 0 && expected_views.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // watchdog: several times the slowest legal run
  initial begin
    #2_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

### sim.f
src/scb_pkg.sv
src/scb_ram.sv
src/scb_mul.sv
src/scaled_clock_bank.sv
src/scb_checker.sv
dv/testbench.sv
